/* rtl/core/lfpd_pkg.sv */
package lfpd_pkg;

   localparam int SAMPLE_W    = 10;
   localparam int GAIN_W      = 16;
   localparam int MAX_SPEED_W = 15;
   localparam int SPEED_W     = 16;
   localparam int ERR_W       = 15;
   localparam int ERR_MAG_W   = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int DELTA_LIMIT_DEFAULT = 300;

   localparam logic [SAMPLE_W-1:0]    DARK_THRESHOLD_RESET       = 10'd300;
   localparam logic [SAMPLE_W-1:0]    SUPER_DARK_THRESHOLD_RESET = 10'd150;
   localparam logic [GAIN_W-1:0]      GAIN_MILLI_RESET           = 16'd100;
   localparam logic [MAX_SPEED_W-1:0] MAX_SPEED_RESET            = 15'd1000;

   // Error magnitudes picked by the steering rules
   localparam logic [ERR_MAG_W-1:0] ERR_MAG_NONE  = 14'd0;
   localparam logic [ERR_MAG_W-1:0] ERR_MAG_SMALL = 14'd1000;
   localparam logic [ERR_MAG_W-1:0] ERR_MAG_MID   = 14'd5000;
   localparam logic [ERR_MAG_W-1:0] ERR_MAG_FULL  = 14'd10000;

   // floor(x / 3) = (x * 87382) >> 18, exact for x < 2**16
   localparam logic [16:0] DIV3_RECIP = 17'd87382;
   localparam int          DIV3_SHIFT = 18;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DARK_THRESHOLD       = 3'd0,
      CSR_SUPER_DARK_THRESHOLD = 3'd1,
      CSR_GAIN_MILLI           = 3'd2,
      CSR_MAX_SPEED_LEFT       = 3'd3,
      CSR_MAX_SPEED_RIGHT      = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                 neg;
      logic [ERR_MAG_W-1:0] mag;
      logic                 full;
   } steer_type;

   function automatic logic [MAX_SPEED_W-1:0] two_thirds(input logic [MAX_SPEED_W-1:0] max_speed);
      logic [MAX_SPEED_W:0] dbl;
      logic [32:0]          prod;
      dbl  = {max_speed, 1'b0};
      prod = {17'd0, dbl} * {16'd0, DIV3_RECIP};
      return prod[DIV3_SHIFT +: MAX_SPEED_W];
   endfunction

endpackage

/* rtl/core/line_follow_proportional_drive_unit.sv */
// Two-sensor proportional line follower drive.
// Request channel (req_valid / req_stall): one word carries a raw left and
// right reflectance sample. Response channel (rsp_valid / rsp_stall): one
// word per request with left and right wheel speed and the alignment error.
// A word moves at a clock edge where valid is high and stall is low.
// The word sits in the input register while the steering rules, the
// proportional delta, clip and saturate settle into the response register.
// Throughput: one word per cycle, back to back, while rsp_stall stays low.
// When the receiver stalls, the response register holds its word and the
// input register takes one more; req_stall rises once both hold a word and
// the response is blocked, and drops as soon as rsp_stall drops.
// Configuration (csr_write_en / csr_index / csr_data) is for the user to write
// only while the block is idle; the block does not enforce it. Writes to unknown
// indexes are dropped. Reset (synchronous, active high) empties both registers,
// restores register defaults and sets the last-seen side to the right.
module line_follow_proportional_drive_unit
   import lfpd_pkg::*;
#(
   parameter int DELTA_LIMIT = DELTA_LIMIT_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_W-1:0]       req_left_sample,
   input  logic [SAMPLE_W-1:0]       req_right_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SPEED_W-1:0] rsp_left_speed,
   output logic signed [SPEED_W-1:0] rsp_right_speed,
   output logic signed [ERR_W-1:0]   rsp_alignment_error,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_data
);

   localparam int DELTA_W = 19;
   localparam logic signed [DELTA_W-1:0] LIMIT_POS = DELTA_W'(DELTA_LIMIT);
   localparam logic signed [DELTA_W-1:0] LIMIT_NEG = DELTA_W'(-DELTA_LIMIT);
   localparam logic signed [DELTA_W-1:0] SPEED_HI  = DELTA_W'(32767);
   localparam logic signed [DELTA_W-1:0] SPEED_LO  = DELTA_W'(-32768);

   // configuration registers
   logic [SAMPLE_W-1:0]    dark_threshold_ff;
   logic [SAMPLE_W-1:0]    super_dark_threshold_ff;
   logic [GAIN_W-1:0]      gain_milli_ff;
   logic [MAX_SPEED_W-1:0] max_speed_left_ff;
   logic [MAX_SPEED_W-1:0] max_speed_right_ff;
   logic [MAX_SPEED_W-1:0] base_left_ff;
   logic [MAX_SPEED_W-1:0] base_right_ff;

   // register handshake
   logic take_out;
   logic take_in;

   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_left_ff;
   logic [SAMPLE_W-1:0] s1_right_ff;

   steer_type                 steer;
   logic signed [DELTA_W-1:0] gain_ext;
   logic signed [DELTA_W-1:0] gain_x5;
   logic signed [DELTA_W-1:0] delta_raw;
   logic signed [DELTA_W-1:0] delta_dir;
   logic signed [DELTA_W-1:0] delta;
   logic signed [DELTA_W-1:0] sum_left;
   logic signed [DELTA_W-1:0] sum_right;
   logic signed [SPEED_W-1:0] sat_left;
   logic signed [SPEED_W-1:0] sat_right;
   logic signed [SPEED_W-1:0] max_left_s;
   logic signed [SPEED_W-1:0] max_right_s;

   logic                      rsp_valid_ff;
   logic signed [SPEED_W-1:0] rsp_left_speed_ff;
   logic signed [SPEED_W-1:0] rsp_left_speed_in;
   logic signed [SPEED_W-1:0] rsp_right_speed_ff;
   logic signed [SPEED_W-1:0] rsp_right_speed_in;
   logic signed [ERR_W-1:0]   rsp_alignment_error_ff;
   logic signed [ERR_W-1:0]   rsp_alignment_error_in;

   // ---------------------------------------------------------------
   // Configuration: keep only each register's width
   // ---------------------------------------------------------------
   // Base speeds load together with their max-speed register, so a word
   // accepted right after a write already sees the new base.
   always_ff @(posedge clock) begin
      if (reset) begin
         dark_threshold_ff       <= DARK_THRESHOLD_RESET;
         super_dark_threshold_ff <= SUPER_DARK_THRESHOLD_RESET;
         gain_milli_ff           <= GAIN_MILLI_RESET;
         max_speed_left_ff       <= MAX_SPEED_RESET;
         max_speed_right_ff      <= MAX_SPEED_RESET;
         base_left_ff            <= two_thirds(MAX_SPEED_RESET);
         base_right_ff           <= two_thirds(MAX_SPEED_RESET);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DARK_THRESHOLD:       dark_threshold_ff       <= csr_data[SAMPLE_W-1:0];
            CSR_SUPER_DARK_THRESHOLD: super_dark_threshold_ff <= csr_data[SAMPLE_W-1:0];
            CSR_GAIN_MILLI:           gain_milli_ff           <= csr_data[GAIN_W-1:0];
            CSR_MAX_SPEED_LEFT: begin
               max_speed_left_ff <= csr_data[MAX_SPEED_W-1:0];
               base_left_ff      <= two_thirds(csr_data[MAX_SPEED_W-1:0]);
            end
            CSR_MAX_SPEED_RIGHT: begin
               max_speed_right_ff <= csr_data[MAX_SPEED_W-1:0];
               base_right_ff      <= two_thirds(csr_data[MAX_SPEED_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Handshake: a register loads when empty or when its word moves on
   // ---------------------------------------------------------------
   assign take_out  = !rsp_valid_ff || !rsp_stall;
   assign take_in   = !s1_valid_ff || take_out;
   assign req_stall = !take_in;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take_in) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_in && req_valid) begin
         s1_left_ff  <= req_left_sample;
         s1_right_ff <= req_right_sample;
      end
   end

   // Steering rules; side memory advances when the word moves on
   lfpd_steer u_steer (
      .clock                (clock),
      .reset                (reset),
      .advance              (s1_valid_ff && take_out),
      .left_sample          (s1_left_ff),
      .right_sample         (s1_right_ff),
      .dark_threshold       (dark_threshold_ff),
      .super_dark_threshold (super_dark_threshold_ff),
      .steer                (steer)
   );

   // Below full error the magnitude is 0, 1000 or 5000, so error * gain / 1000
   // is exactly zero, one or five times the gain: no division is left.
   assign gain_ext = {{(DELTA_W-GAIN_W){gain_milli_ff[GAIN_W-1]}}, gain_milli_ff};
   assign gain_x5  = (gain_ext <<< 2) + gain_ext;

   always_comb begin
      case (steer.mag)
         ERR_MAG_SMALL: begin
            delta_raw = gain_ext;
         end
         ERR_MAG_MID: begin
            delta_raw = gain_x5;
         end
         default: begin
            delta_raw = '0;
         end
      endcase
      delta_dir = steer.neg ? -delta_raw : delta_raw;
      if (delta_dir > LIMIT_POS) begin
         delta = LIMIT_POS;
      end else if (delta_dir < LIMIT_NEG) begin
         delta = LIMIT_NEG;
      end else begin
         delta = delta_dir;
      end
   end

   // Add to base, saturate; full error spins in place
   assign sum_left  = $signed({{(DELTA_W-MAX_SPEED_W){1'b0}}, base_left_ff}) + delta;
   assign sum_right = $signed({{(DELTA_W-MAX_SPEED_W){1'b0}}, base_right_ff}) - delta;

   always_comb begin
      if (sum_left > SPEED_HI) begin
         sat_left = 16'sh7FFF;
      end else if (sum_left < SPEED_LO) begin
         sat_left = 16'sh8000;
      end else begin
         sat_left = sum_left[SPEED_W-1:0];
      end
      if (sum_right > SPEED_HI) begin
         sat_right = 16'sh7FFF;
      end else if (sum_right < SPEED_LO) begin
         sat_right = 16'sh8000;
      end else begin
         sat_right = sum_right[SPEED_W-1:0];
      end
   end

   assign max_left_s  = $signed({1'b0, max_speed_left_ff});
   assign max_right_s = $signed({1'b0, max_speed_right_ff});

   always_comb begin
      if (steer.full) begin
         rsp_left_speed_in  = steer.neg ? -max_left_s : max_left_s;
         rsp_right_speed_in = steer.neg ? max_right_s : -max_right_s;
      end else begin
         rsp_left_speed_in  = sat_left;
         rsp_right_speed_in = sat_right;
      end
      rsp_alignment_error_in = steer.neg ? -$signed({1'b0, steer.mag})
                                         :  $signed({1'b0, steer.mag});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take_out) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take_out && s1_valid_ff) begin
         rsp_left_speed_ff      <= rsp_left_speed_in;
         rsp_right_speed_ff     <= rsp_right_speed_in;
         rsp_alignment_error_ff <= rsp_alignment_error_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_left_speed      = rsp_left_speed_ff;
   assign rsp_right_speed     = rsp_right_speed_ff;
   assign rsp_alignment_error = rsp_alignment_error_ff;

`ifndef SYNTHESIS
   a_err_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alignment_error == 15'sd0 ||
                     rsp_alignment_error == 15'sd1000 ||
                     rsp_alignment_error == -15'sd1000 ||
                     rsp_alignment_error == 15'sd5000 ||
                     rsp_alignment_error == -15'sd5000 ||
                     rsp_alignment_error == 15'sd10000 ||
                     rsp_alignment_error == -15'sd10000))
      else $error("alignment error outside the rule set");

   a_full_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alignment_error == 15'sd10000 |->
         rsp_left_speed == max_left_s && rsp_right_speed == -max_right_s)
      else $error("full right error without opposite spin");

   a_full_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alignment_error == -15'sd10000 |->
         rsp_left_speed == -max_left_s && rsp_right_speed == max_right_s)
      else $error("full left error without opposite spin");

   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall && s1_valid_ff)
      else $error("request stalled while the block has room");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_speed) &&
         $stable(rsp_right_speed) && $stable(rsp_alignment_error))
      else $error("stalled response word changed");
`endif

endmodule

/* rtl/core/lfpd_steer.sv */
module lfpd_steer
   import lfpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [SAMPLE_W-1:0] left_sample,
   input  logic [SAMPLE_W-1:0] right_sample,
   input  logic [SAMPLE_W-1:0] dark_threshold,
   input  logic [SAMPLE_W-1:0] super_dark_threshold,
   output steer_type           steer
);

   logic [SAMPLE_W-1:0] inv_l;
   logic [SAMPLE_W-1:0] inv_r;
   logic                dl;
   logic                sl;
   logic                dr;
   logic                sr;
   logic                last_seen_left_ff;
   logic                last_seen_left_in;

   // 1023 - sample is the bitwise complement of a 10-bit sample
   assign inv_l = ~left_sample;
   assign inv_r = ~right_sample;
   assign dl    = (inv_l <= dark_threshold);
   assign sl    = (inv_l <= super_dark_threshold);
   assign dr    = (inv_r <= dark_threshold);
   assign sr    = (inv_r <= super_dark_threshold);

   always_comb begin
      if (dl) begin
         last_seen_left_in = 1'b1;
      end else if (dr) begin
         last_seen_left_in = 1'b0;
      end else begin
         last_seen_left_in = last_seen_left_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seen_left_ff <= 1'b0;
      end else if (advance) begin
         last_seen_left_ff <= last_seen_left_in;
      end
   end

   // Priority rules; lost line steers toward the side seen last
   always_comb begin
      steer.full = 1'b0;
      steer.neg  = 1'b0;
      steer.mag  = ERR_MAG_NONE;
      if (dl && dr) begin
         steer.mag = ERR_MAG_NONE;
      end else if (sr) begin
         steer.mag = ERR_MAG_SMALL;
      end else if (dr) begin
         steer.mag = ERR_MAG_MID;
      end else if (sl) begin
         steer.neg = 1'b1;
         steer.mag = ERR_MAG_SMALL;
      end else if (dl) begin
         steer.neg = 1'b1;
         steer.mag = ERR_MAG_MID;
      end else begin
         steer.full = 1'b1;
         steer.neg  = last_seen_left_in;
         steer.mag  = ERR_MAG_FULL;
      end
   end

endmodule

/* verif/line_follow_proportional_drive_unit_tb.sv */
`timescale 1ns / 100ps

module line_follow_proportional_drive_unit_tb;
   import lfpd_pkg::*;

   // One response word as the block presents it
   typedef struct packed {
      logic signed [SPEED_W-1:0] left;
      logic signed [SPEED_W-1:0] right;
      logic signed [ERR_W-1:0]   err;
   } drive_word_type;

   // One row of the directed script; pinned rows carry their answer
   typedef struct packed {
      logic [SAMPLE_W-1:0] left;
      logic [SAMPLE_W-1:0] right;
      logic                pinned;
      drive_word_type      want;
   } sample_row_type;

   localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
   localparam int SPEED_MIN       = -(1 << (SPEED_W - 1));
   localparam int SPEED_MAX       = (1 << (SPEED_W - 1)) - 1;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES    = 20;
   localparam int REPORT_LIMIT    = 10;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_W-1:0]       req_left_sample;
   logic [SAMPLE_W-1:0]       req_right_sample;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic signed [SPEED_W-1:0] rsp_left_speed;
   logic signed [SPEED_W-1:0] rsp_right_speed;
   logic signed [ERR_W-1:0]   rsp_alignment_error;
   logic                      csr_write_en;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]     csr_data;

   // Pinned answer travels with the word it belongs to
   logic           cur_pinned;
   drive_word_type cur_want;

   // Shadow copy of the steering registers and side memory
   logic [SAMPLE_W-1:0]       m_dark;
   logic [SAMPLE_W-1:0]       m_super;
   logic signed [GAIN_W-1:0]  m_gain;
   logic [MAX_SPEED_W-1:0]    m_max_l;
   logic [MAX_SPEED_W-1:0]    m_max_r;
   logic                      m_seen_left;

   drive_word_type pending_drive [$];
   int             drive_mismatches = 0;

   // Percent chances of an idle burst per word and of a stall burst; hold_off asks for one long stall
   int gap_pct   = 20;
   int stall_pct = 20;
   int hold_off  = 0;

   line_follow_proportional_drive_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_left_sample     (req_left_sample),
      .req_right_sample    (req_right_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_left_speed      (rsp_left_speed),
      .rsp_right_speed     (rsp_right_speed),
      .rsp_alignment_error (rsp_alignment_error),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int clamp(input int v, input int lo, input int hi);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Mirror a register write; keep only the register's width, drop unknown indexes
   function automatic void load_reg(input logic [CSR_INDEX_W-1:0] idx,
                                    input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_DARK_THRESHOLD:       m_dark  = data[SAMPLE_W-1:0];
         CSR_SUPER_DARK_THRESHOLD: m_super = data[SAMPLE_W-1:0];
         CSR_GAIN_MILLI:           m_gain  = data[GAIN_W-1:0];
         CSR_MAX_SPEED_LEFT:       m_max_l = data[MAX_SPEED_W-1:0];
         CSR_MAX_SPEED_RIGHT:      m_max_r = data[MAX_SPEED_W-1:0];
         default: ;
      endcase
   endfunction

   // Work out the wheel speeds and error for one sample pair; advances side memory
   function automatic drive_word_type steer_predict(input logic [SAMPLE_W-1:0] l,
                                                    input logic [SAMPLE_W-1:0] r);
      int             inv_l, inv_r, err, delta, spl, spr;
      bit             dl, sl, dr, sr;
      drive_word_type w;
      inv_l = SAMPLE_MAX - int'(l);
      inv_r = SAMPLE_MAX - int'(r);
      dl = inv_l <= int'(m_dark);
      sl = inv_l <= int'(m_super);
      dr = inv_r <= int'(m_dark);
      sr = inv_r <= int'(m_super);
      if (dl) m_seen_left = 1'b1;
      else if (dr) m_seen_left = 1'b0;
      if (dl && dr) err = int'(ERR_MAG_NONE);
      else if (sr) err = int'(ERR_MAG_SMALL);
      else if (dr) err = int'(ERR_MAG_MID);
      else if (sl) err = -int'(ERR_MAG_SMALL);
      else if (dl) err = -int'(ERR_MAG_MID);
      else err = m_seen_left ? -int'(ERR_MAG_FULL) : int'(ERR_MAG_FULL);
      if (err == int'(ERR_MAG_FULL) || err == -int'(ERR_MAG_FULL)) begin
         // spin in place at full speed
         spl = (err > 0) ? int'(m_max_l) : -int'(m_max_l);
         spr = (err > 0) ? -int'(m_max_r) : int'(m_max_r);
      end else begin
         // SV division truncates toward zero
         delta = clamp((err * int'(m_gain)) / 1000,
                       -DELTA_LIMIT_DEFAULT, DELTA_LIMIT_DEFAULT);
         spl = clamp((2 * int'(m_max_l)) / 3 + delta, SPEED_MIN, SPEED_MAX);
         spr = clamp((2 * int'(m_max_r)) / 3 - delta, SPEED_MIN, SPEED_MAX);
      end
      w.left  = SPEED_W'(spl);
      w.right = SPEED_W'(spr);
      w.err   = ERR_W'(err);
      return w;
   endfunction

   function automatic sample_row_type fixed_row(input int l, input int r, input int ls,
                                                input int rs, input int e);
      sample_row_type row;
      row.left       = SAMPLE_W'(l);
      row.right      = SAMPLE_W'(r);
      row.pinned     = 1'b1;
      row.want.left  = SPEED_W'(ls);
      row.want.right = SPEED_W'(rs);
      row.want.err   = ERR_W'(e);
      return row;
   endfunction

   function automatic sample_row_type model_row(input int l, input int r);
      sample_row_type row;
      row        = '0;
      row.left   = SAMPLE_W'(l);
      row.right  = SAMPLE_W'(r);
      return row;
   endfunction

   // Pick a raw sample, often near or between the current thresholds
   function automatic logic [SAMPLE_W-1:0] pick_sample(input bit lost);
      int inv;
      if (lost) begin
         inv = $urandom_range(int'(m_dark) + 1, SAMPLE_MAX);
      end else begin
         case ($urandom_range(0, 4))
            0: inv = $urandom_range(0, SAMPLE_MAX);
            1: inv = $urandom_range(0, int'(m_super));
            2: inv = $urandom_range(int'(m_super), int'(m_dark));
            3: inv = ($urandom_range(0, 1) ? int'(m_dark) : int'(m_super))
                     + $urandom_range(0, 4) - 2;
            default: inv = $urandom_range(int'(m_dark), SAMPLE_MAX);
         endcase
      end
      inv = clamp(inv, 0, SAMPLE_MAX);
      return SAMPLE_W'(SAMPLE_MAX - inv);
   endfunction

   task automatic report(input string what, input int want_v, input int got_v);
      drive_mismatches++;
      if (drive_mismatches <= REPORT_LIMIT)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
   endtask

   // Offer one word and hold it until the block takes it
   task automatic push_word(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                            input logic pinned, input drive_word_type want);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_left_sample  <= l;
      req_right_sample <= r;
      cur_pinned       <= pinned;
      cur_want         <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // Advance at least one edge so the last accepted word is queued, then drain
   task automatic wait_idle();
      do @(posedge clock); while (pending_drive.size() != 0);
   endtask

   // Poke the unused indexes with junk, then load every register, with stray high bits above each narrower one
   task automatic program_regs(input int regs [5]);
      logic [31:0] csr_word;
      int          width;
      for (int i = CSR_MAX_SPEED_RIGHT + 1; i < (1 << CSR_INDEX_W); i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_INDEX_W'(i);
         csr_data     <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      for (int i = CSR_DARK_THRESHOLD; i <= CSR_MAX_SPEED_RIGHT; i++) begin
         case (i)
            CSR_GAIN_MILLI:                          width = GAIN_W;
            CSR_MAX_SPEED_LEFT, CSR_MAX_SPEED_RIGHT: width = MAX_SPEED_W;
            default:                                 width = SAMPLE_W;
         endcase
         csr_word = ($urandom << width) | (regs[i] & ((1 << width) - 1));
         csr_write_en <= 1'b1;
         csr_index    <= CSR_INDEX_W'(i);
         csr_data     <= csr_word[CSR_DATA_W-1:0];
         @(posedge clock);
      end
      csr_write_en <= 1'b0;
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off) @(posedge clock);
            hold_off = 0;
            rsp_stall <= 1'b0;
         end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Track both channels at each edge: predict on accept, check on delivery
   always @(posedge clock) begin : track_words
      drive_word_type want;
      drive_word_type got;
      if (reset) begin
         pending_drive.delete();
         m_dark      = DARK_THRESHOLD_RESET;
         m_super     = SUPER_DARK_THRESHOLD_RESET;
         m_gain      = GAIN_MILLI_RESET;
         m_max_l     = MAX_SPEED_RESET;
         m_max_r     = MAX_SPEED_RESET;
         m_seen_left = 1'b0;
      end else begin
         if (csr_write_en)
            load_reg(csr_index, csr_data);
         if (req_valid && !req_stall) begin
            // run the predictor even for pinned rows so side memory stays in step
            want = steer_predict(req_left_sample, req_right_sample);
            if (cur_pinned)
               want = cur_want;
            pending_drive.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.left  = rsp_left_speed;
            got.right = rsp_right_speed;
            got.err   = rsp_alignment_error;
            if (pending_drive.size() == 0) begin
               report("response word with nothing pending", 0, 1);
            end else begin
               want = pending_drive.pop_front();
               if (got.left !== want.left)
                  report("left_speed", int'(want.left), int'(got.left));
               if (got.right !== want.right)
                  report("right_speed", int'(want.right), int'(got.right));
               if (got.err !== want.err)
                  report("alignment_error", int'(want.err), int'(got.err));
            end
         end
      end
   end

   initial begin
      sample_row_type script [$];
      int             regs [5];
      bit             lost;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_left_sample  <= '0;
      req_right_sample <= '0;
      cur_pinned       <= 1'b0;
      cur_want         <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;

      // Directed script under reset settings: dark 300, super dark 150,
      // gain 100, both max speeds 1000 (two thirds is 666)
      script = '{
         fixed_row(0, 0, 1000, -1000, 10000),     // line lost, right seen last
         fixed_row(1023, 1023, 666, 666, 0),      // both dark: on track
         fixed_row(0, 0, -1000, 1000, -10000),    // line lost, left seen last
         model_row(0, 1000),                      // right super dark
         model_row(0, 800),                       // right dark only, delta clips
         model_row(1000, 0),                      // left super dark
         model_row(800, 0),                       // left dark only
         model_row(0, 0),                         // lost again after left
         model_row(0, 723),                       // right exactly at dark threshold
         model_row(722, 0),                       // left one past dark: lost
         model_row(873, 0),                       // left exactly at super dark
         model_row(0, 872),                       // right one past super dark
         model_row(1023, 0),                      // left full dark
         model_row(0, 1023),                      // right full dark
         model_row(1000, 800),                    // both dark, left centered
         model_row(800, 1000),                    // both dark, right centered
         model_row(1023, 722),                    // right just misses dark
         model_row(722, 722),                     // both just miss: lost
         model_row(723, 0),                       // left at dark threshold
         model_row(0, 0),                         // lost after left
         model_row(0, 1000),                      // back to the right
         model_row(0, 0)                          // lost after right
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i])
         push_word(script[i].left, script[i].right, script[i].pinned, script[i].want);
      req_valid <= 1'b0;
      wait_idle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: regs = '{1023, 1023, 32767, 32767, 32767};   // everything reads dark
            1: regs = '{0, 0, -32768, 0, 0};               // only full dark counts
            2: regs = '{600, 100, -32768, 32767, 32767};   // heavy negative gain
            3: regs = '{400, 400, 0, 3, 32766};            // equal thresholds, no gain
            4: regs = '{200, 800, 1000, 1000, 500};        // super dark above dark
            default: begin
               regs[0] = $urandom_range(0, SAMPLE_MAX);
               regs[1] = $urandom_range(0, 3) ? $urandom_range(0, regs[0])
                                              : $urandom_range(0, SAMPLE_MAX);
               regs[2] = $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                              : $urandom_range(0, 240) - 120;
               regs[3] = $urandom_range(0, 32767);
               regs[4] = $urandom_range(0, 32767);
            end
         endcase
         // quiet stretches now and then; none at all in the last phase
         if (p == PHASES - 1) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = (p == 2) ? 0 : $urandom_range(0, 3) * 10;
            stall_pct = $urandom_range(0, 3) * 10;
         end
         program_regs(regs);

         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            // hold the receiver off while words keep coming, so the block backs up
            if (p == 2 && k == 10)
               hold_off = HOLD_OFF_CYCLES;
            // drop valid and let every pending word come out before going on
            if (p == 5 && k == ITEMS_PER_PHASE / 2) begin
               req_valid <= 1'b0;
               wait_idle();
            end
            lost = $urandom_range(0, 4) == 0;
            push_word(pick_sample(lost), pick_sample(lost), 1'b0, '0);
         end
         req_valid <= 1'b0;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_drive.size() != 0)
         report("words never returned", 0, pending_drive.size());

      if (drive_mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog: well past the slowest legal run
   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
